// ===== rtl/bcd_pkg.sv =====
// ----------------------------------------------------------------------------
// bcd_pkg
// shared types and constants for the button click detector
// ----------------------------------------------------------------------------
package bcd_pkg;

	localparam int TIMER_BITS_DEFAULT = 16;
	localparam int CFG_W              = 16;
	localparam int APB_DATA_W         = 32;
	localparam int APB_ADDR_W         = 3;

	localparam logic [CFG_W-1:0] DEBOUNCE_RESET = CFG_W'(50);
	localparam logic [CFG_W-1:0] DCLICK_RESET   = CFG_W'(300);

	// register indexes, taken from paddr[2]
	localparam logic REG_DEBOUNCE = 1'b0;
	localparam logic REG_DCLICK   = 1'b1;

	// click status codes
	localparam logic [1:0] STATUS_NONE   = 2'd0;
	localparam logic [1:0] STATUS_SINGLE = 2'd1;
	localparam logic [1:0] STATUS_DOUBLE = 2'd2;

	typedef struct packed {
		logic button_level;
		logic detect_disabled;
		logic status_clear;
	} in_t;

	typedef struct packed {
		logic [1:0] click_status;
		logic       debounced_level;
	} out_t;

	// detector state besides the timer
	typedef struct packed {
		logic [1:0] click_state;
		logic       last_level;
	} det_state_t;

endpackage

// ===== rtl/bcd_update.sv =====
// ----------------------------------------------------------------------------
// bcd_update
// next-state logic of the detector for one tick
// ----------------------------------------------------------------------------
module bcd_update #(
	parameter int TIMER_BITS = bcd_pkg::TIMER_BITS_DEFAULT
) (
	input  bcd_pkg::in_t                    item,
	input  logic [TIMER_BITS-1:0]           timer,
	input  bcd_pkg::det_state_t             state,
	input  logic [bcd_pkg::CFG_W-1:0]       debounce_ticks,
	input  logic [bcd_pkg::CFG_W-1:0]       double_click_ticks,
	output logic [TIMER_BITS-1:0]           timer_nxt,
	output bcd_pkg::det_state_t             state_nxt
);

	localparam int CMP_W = (TIMER_BITS > bcd_pkg::CFG_W) ? TIMER_BITS : bcd_pkg::CFG_W;

	logic [1:0]            cs;
	logic [TIMER_BITS-1:0] t_inc;
	logic [CMP_W-1:0]      t_cmp;
	logic [CMP_W-1:0]      deb_cmp;
	logic [CMP_W-1:0]      dcl_cmp;
	logic                  edge_ok;
	logic                  in_window;

	assign cs      = item.status_clear ? bcd_pkg::STATUS_NONE : state.click_state;
	// saturating increment
	assign t_inc   = (&timer) ? timer : timer + TIMER_BITS'(1);
	assign t_cmp   = CMP_W'(t_inc);
	assign deb_cmp = CMP_W'(debounce_ticks);
	assign dcl_cmp = CMP_W'(double_click_ticks);
	assign edge_ok = (t_cmp >= deb_cmp) && (item.button_level != state.last_level);
	assign in_window = t_cmp < dcl_cmp;

	always_comb begin
		state_nxt.click_state = cs;
		state_nxt.last_level  = state.last_level;
		timer_nxt             = timer;
		if (!item.detect_disabled) begin
			timer_nxt = t_inc;
			if (edge_ok) begin
				state_nxt.last_level = item.button_level;
				if (item.button_level) begin
					if (cs == bcd_pkg::STATUS_NONE ||
					    (cs == bcd_pkg::STATUS_SINGLE && in_window)) begin
						timer_nxt = '0;
					end
				end else begin
					if (cs == bcd_pkg::STATUS_NONE) begin
						state_nxt.click_state = bcd_pkg::STATUS_SINGLE;
						timer_nxt             = '0;
					end else if (cs == bcd_pkg::STATUS_SINGLE && in_window) begin
						state_nxt.click_state = bcd_pkg::STATUS_DOUBLE;
						timer_nxt             = '0;
					end
				end
			end
		end
	end

endmodule

// ===== rtl/button_click_detector_core.sv =====
// ----------------------------------------------------------------------------
// button_click_detector_core
// debounce and single/double click detection on a millisecond tick stream
// ----------------------------------------------------------------------------
// usage:
//   in channel: one item per tick with the sampled button level, a disable
//   flag and a status clear flag; accepted when in_valid is high and
//   in_stall is low
//   out channel: one item per input item with the click status and the
//   debounced level as they stand after that tick
//   path: the item waits in the input register, then the update logic loads
//   the result register and out_valid rises; the result is taken at an edge
//   where out_stall is low
//   throughput: one item per cycle unless stalled; the timer and click state
//   update is a saturating increment and two compares, done in the result stage
//   stall: when out_stall holds a result, the input register keeps its item
//   and in_stall rises in the same cycle; nothing is dropped
//   reset: timer, level and click state clear, thresholds return to 50 and
//   300 ticks, both registers empty
//   config: APB writes at 0 (debounce ticks) and 4 (double click ticks),
//   only while no item is in flight
// ----------------------------------------------------------------------------
module button_click_detector_core #(
	parameter int TIMER_BITS = bcd_pkg::TIMER_BITS_DEFAULT
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// input channel
	input  logic                               in_valid,
	output logic                               in_stall,
	input  bcd_pkg::in_t                       in_data,
	// output channel
	output logic                               out_valid,
	input  logic                               out_stall,
	output bcd_pkg::out_t                      out_data,
	// config port
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [bcd_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [bcd_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [bcd_pkg::APB_DATA_W-1:0]     prdata,
	output logic                               pready
);

	// config registers
	logic [bcd_pkg::CFG_W-1:0] debounce_q;
	logic [bcd_pkg::CFG_W-1:0] dclick_q;

	// input stage
	logic         valid_s1;
	bcd_pkg::in_t item_s1;

	// detector state
	logic [TIMER_BITS-1:0] timer_q;
	bcd_pkg::det_state_t   state_q;

	// result stage
	logic          valid_s2;
	bcd_pkg::out_t result_s2;

	logic                  adv_s2;
	logic                  in_take;
	logic                  cfg_wr;
	logic [TIMER_BITS-1:0] timer_nxt;
	bcd_pkg::det_state_t   state_nxt;

	// result register can load when empty or being drained
	assign adv_s2   = valid_s1 && (!valid_s2 || !out_stall);
	// input register frees up whenever its item moves on
	assign in_stall = valid_s1 && !adv_s2;
	assign in_take  = in_valid && !in_stall;

	assign out_valid = valid_s2;
	assign out_data  = result_s2;

	// config access, always ready
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		unique case (paddr[2])
			bcd_pkg::REG_DEBOUNCE: prdata = bcd_pkg::APB_DATA_W'(debounce_q);
			bcd_pkg::REG_DCLICK:   prdata = bcd_pkg::APB_DATA_W'(dclick_q);
			default:               prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= bcd_pkg::DEBOUNCE_RESET;
			dclick_q   <= bcd_pkg::DCLICK_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == bcd_pkg::REG_DEBOUNCE) begin
				debounce_q <= pwdata[bcd_pkg::CFG_W-1:0];
			end else begin
				dclick_q <= pwdata[bcd_pkg::CFG_W-1:0];
			end
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (adv_s2) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1 <= in_data;
		end
	end

	bcd_update #(
		.TIMER_BITS(TIMER_BITS)
	) u_update (
		.item               (item_s1),
		.timer              (timer_q),
		.state              (state_q),
		.debounce_ticks     (debounce_q),
		.double_click_ticks (dclick_q),
		.timer_nxt          (timer_nxt),
		.state_nxt          (state_nxt)
	);

	// state and result commit together as the item enters the result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_q  <= '0;
			state_q  <= '{click_state: bcd_pkg::STATUS_NONE, last_level: 1'b0};
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s2) begin
				timer_q  <= timer_nxt;
				state_q  <= state_nxt;
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			result_s2.click_status    <= state_nxt.click_state;
			result_s2.debounced_level <= state_nxt.last_level;
		end
	end

	// status code three is unreachable
	a_no_status3: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.click_state != 2'd3)
		else $error("click state reached unused code");

	// state moves only with an item entering the result stage
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s2 |=> $stable(state_q) && $stable(timer_q))
		else $error("detector state changed without an item");

	// result register mirrors the committed state
	a_result_match: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s2 |=> result_s2.click_status == state_q.click_state &&
		           result_s2.debounced_level == state_q.last_level)
		else $error("result does not match committed state");

	// double click only follows a single click or a held double
	a_double_seq: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s2 && state_nxt.click_state == bcd_pkg::STATUS_DOUBLE &&
		state_q.click_state == bcd_pkg::STATUS_NONE |-> 1'b0)
		else $error("double click without a prior single click");

endmodule

// ===== tb/sv/button_click_detector_core_test.sv =====
// ----------------------------------------------------------------------------
// button_click_detector_core_test
// self-checking bench for the debounce and click detector core
// ----------------------------------------------------------------------------
// a short stimulus table walks the click sequences and corner cases (edge
// after a double click, late second click, clear while frozen), then random
// press/release runs are sent under several threshold settings; every output
// item is compared with a bench-side model of the detector (typed table rows
// with their own entries), with bursty input and a random output stall
// ----------------------------------------------------------------------------
module button_click_detector_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TMR_W = bcd_pkg::TIMER_BITS_DEFAULT;
	localparam int LIMIT = 1000000;
	localparam int HOLD_CYCLES = 64;
	localparam int NDIR = 18;
	localparam int THR_ROW = 3;        // thresholds get shortened before this row
	localparam int NPHASE = 8;

	// ------------------------------------------------------------------------
	// dut hookup
	// ------------------------------------------------------------------------
	logic                           clk;
	logic                           arst_n;
	logic                           in_valid;
	logic                           in_stall;
	bcd_pkg::in_t                   in_data;
	logic                           out_valid;
	logic                           out_stall;
	bcd_pkg::out_t                  out_data;
	logic                           psel;
	logic                           penable;
	logic                           pwrite;
	logic [bcd_pkg::APB_ADDR_W-1:0] paddr;
	logic [bcd_pkg::APB_DATA_W-1:0] pwdata;
	logic [bcd_pkg::APB_DATA_W-1:0] prdata;
	logic                           pready;

	button_click_detector_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// 12 ns clock
	initial clk = 1'b0;
	always #6 clk = ~clk;

	// ------------------------------------------------------------------------
	// detector model: thresholds, timer, accepted level and click status
	// ------------------------------------------------------------------------
	logic [bcd_pkg::CFG_W-1:0] db_ticks = bcd_pkg::DEBOUNCE_RESET;
	logic [bcd_pkg::CFG_W-1:0] dc_ticks = bcd_pkg::DCLICK_RESET;
	logic [TMR_W-1:0]          press_cnt = '0;
	logic                      level_q = 1'b0;
	logic [1:0]                status_q = bcd_pkg::STATUS_NONE;

	bcd_pkg::out_t pending_clicks [$];
	int            mismatch_cnt = 0;

	// one tick of the detector, returns the status as it stands afterwards
	function automatic bcd_pkg::out_t click_predict(bcd_pkg::in_t t);
		bcd_pkg::out_t r;
		logic in_win;
		// clear goes first and is not blocked by the disable flag
		if (t.status_clear)
			status_q = bcd_pkg::STATUS_NONE;
		if (!t.detect_disabled) begin
			// saturating tick count
			if (press_cnt != {TMR_W{1'b1}})
				press_cnt = press_cnt + 1'b1;
			if (press_cnt >= TMR_W'(db_ticks) && t.button_level != level_q) begin
				in_win = press_cnt < TMR_W'(dc_ticks);
				level_q = t.button_level;
				if (t.button_level) begin
					// a press only restarts the timer while a sequence can go on
					if (status_q == bcd_pkg::STATUS_NONE ||
					    (status_q == bcd_pkg::STATUS_SINGLE && in_win))
						press_cnt = '0;
				end else begin
					if (status_q == bcd_pkg::STATUS_NONE) begin
						status_q = bcd_pkg::STATUS_SINGLE;
						press_cnt = '0;
					end else if (status_q == bcd_pkg::STATUS_SINGLE && in_win) begin
						status_q = bcd_pkg::STATUS_DOUBLE;
						press_cnt = '0;
					end
					// after a double, or a late second release, only the level moves
				end
			end
		end
		r.click_status = status_q;
		r.debounced_level = level_q;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// input side: bursts of items with random gaps between them
	// ------------------------------------------------------------------------
	bit gappy = 1'b1;
	int burst_left = 0;

	// offer one item, wait for it to be taken, then maybe open a gap
	task automatic send_tick(bcd_pkg::in_t t, bit typed, bcd_pkg::out_t typed_res);
		bcd_pkg::out_t r;
		in_data <= t;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		r = click_predict(t);
		pending_clicks.push_back(typed ? typed_res : r);
		if (gappy) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end else begin
				burst_left--;
			end
		end
	endtask

	// stop sending and let every outstanding item come out
	task automatic drain_wait();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_clicks.size() != 0);
		// two-stage pipe, a few spare cycles are plenty
		repeat (4) @(posedge clk);
	endtask

	// apb write: setup, access, then back to idle
	task automatic cfg_write(logic idx, logic [bcd_pkg::CFG_W-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= bcd_pkg::APB_ADDR_W'({idx, 2'b00});
		pwdata <= bcd_pkg::APB_DATA_W'(val);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == bcd_pkg::REG_DEBOUNCE)
			db_ticks = val;
		else
			dc_ticks = val;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// output side: stall pattern in windows, plus a long hold on request
	// ------------------------------------------------------------------------
	bit hold_go = 1'b0;

	initial begin : rx_side
		int stall_mode;
		int win_left;
		int rx_cnt;
		stall_mode = 0;
		win_left = 0;
		rx_cnt = 0;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			rx_cnt++;
			if (hold_go) begin
				// long hold so the pipe fills and in_stall has to rise
				hold_go = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
			end else begin
				if (win_left == 0) begin
					stall_mode = $urandom_range(0, 3);
					win_left = $urandom_range(16, 128);
				end
				win_left--;
				case (stall_mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					2: out_stall <= ($urandom_range(0, 9) < 6);
					default: out_stall <= (rx_cnt % 4 == 0);
				endcase
			end
		end
	end

	// ------------------------------------------------------------------------
	// output check against the oldest expectation
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : out_check
		bcd_pkg::out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_clicks.size() == 0) begin
				$error("unexpected item: click_status %0d debounced_level %0d",
					out_data.click_status, out_data.debounced_level);
				mismatch_cnt++;
			end else begin
				want = pending_clicks.pop_front();
				if (out_data.click_status !== want.click_status) begin
					$error("click_status: expected %0d, got %0d",
						want.click_status, out_data.click_status);
					mismatch_cnt++;
				end
				if (out_data.debounced_level !== want.debounced_level) begin
					$error("debounced_level: expected %0d, got %0d",
						want.debounced_level, out_data.debounced_level);
					mismatch_cnt++;
				end
			end
		end
	end

	// watchdog
	int cycle_cnt = 0;
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt == LIMIT) begin
			$display("button_click_detector_core_test: done, errors");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// stimulus table
	// ------------------------------------------------------------------------
	typedef struct {
		logic       lvl;
		logic       dis;
		logic       clr;
		int         reps;
		bit         typed;
		logic [1:0] st;
		logic       dl;
	} dir_row_t;

	// lvl dis clr reps typed status level; rows from THR_ROW on run with
	// debounce 2 and double click window 5
	dir_row_t dir_tab [NDIR] = '{
		'{1'b0, 1'b0, 1'b0, 1, 1'b1, bcd_pkg::STATUS_NONE, 1'b0}, // fresh out of reset
		'{1'b1, 1'b0, 1'b0, 1, 1'b1, bcd_pkg::STATUS_NONE, 1'b0}, // press too early
		'{1'b1, 1'b1, 1'b1, 1, 1'b1, bcd_pkg::STATUS_NONE, 1'b0}, // all flags, frozen
		'{1'b1, 1'b0, 1'b0, 1, 1'b0, bcd_pkg::STATUS_NONE, 1'b0}, // first press taken
		'{1'b0, 1'b0, 1'b0, 2, 1'b0, bcd_pkg::STATUS_NONE, 1'b0}, // release, single
		'{1'b1, 1'b0, 1'b0, 2, 1'b0, bcd_pkg::STATUS_NONE, 1'b0}, // second press
		'{1'b0, 1'b0, 1'b0, 2, 1'b0, bcd_pkg::STATUS_NONE, 1'b0}, // release, double
		'{1'b1, 1'b0, 1'b0, 2, 1'b0, bcd_pkg::STATUS_NONE, 1'b0}, // edge after double
		'{1'b0, 1'b0, 1'b0, 1, 1'b0, bcd_pkg::STATUS_NONE, 1'b0}, // status held
		'{1'b1, 1'b1, 1'b1, 1, 1'b1, bcd_pkg::STATUS_NONE, 1'b0}, // clear while frozen
		'{1'b1, 1'b0, 1'b0, 1, 1'b0, bcd_pkg::STATUS_NONE, 1'b0}, // new sequence
		'{1'b0, 1'b0, 1'b0, 2, 1'b0, bcd_pkg::STATUS_NONE, 1'b0}, // single again
		'{1'b0, 1'b0, 1'b0, 4, 1'b0, bcd_pkg::STATUS_NONE, 1'b0}, // window closes
		'{1'b1, 1'b0, 1'b0, 1, 1'b0, bcd_pkg::STATUS_NONE, 1'b0}, // late second press
		'{1'b0, 1'b0, 1'b0, 1, 1'b0, bcd_pkg::STATUS_NONE, 1'b0}, // late release
		'{1'b0, 1'b0, 1'b1, 1, 1'b0, bcd_pkg::STATUS_NONE, 1'b0}, // plain clear
		'{1'b1, 1'b1, 1'b0, 2, 1'b0, bcd_pkg::STATUS_NONE, 1'b0}, // frozen press
		'{1'b1, 1'b0, 1'b1, 1, 1'b0, bcd_pkg::STATUS_NONE, 1'b0}  // clear and press
	};

	// random phases: debounce, double click window, item count
	int phase_db [NPHASE] = '{2, 0, 4, 50, 1, 65535, 0, 7};
	int phase_dc [NPHASE] = '{8, 0, 15, 300, 65535, 0, 65535, 20};
	int phase_n  [NPHASE] = '{250, 150, 250, 400, 150, 60, 120, 270};

	initial begin : main_seq
		bcd_pkg::in_t  t;
		bcd_pkg::out_t res;
		logic run_lvl;
		int   sent;
		int   len;
		int   pick;
		int   k;

		// everything known from time zero
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int r = 0; r < NDIR; r++) begin
			if (r == THR_ROW) begin
				drain_wait();
				cfg_write(bcd_pkg::REG_DEBOUNCE, 16'd2);
				cfg_write(bcd_pkg::REG_DCLICK, 16'd5);
			end
			t.button_level = dir_tab[r].lvl;
			t.detect_disabled = dir_tab[r].dis;
			t.status_clear = dir_tab[r].clr;
			res.click_status = dir_tab[r].st;
			res.debounced_level = dir_tab[r].dl;
			for (int n = 0; n < dir_tab[r].reps; n++)
				send_tick(t, dir_tab[r].typed, res);
		end

		// random press/release runs under each threshold setting
		for (int p = 0; p < NPHASE; p++) begin
			drain_wait();
			cfg_write(bcd_pkg::REG_DEBOUNCE, bcd_pkg::CFG_W'(phase_db[p]));
			cfg_write(bcd_pkg::REG_DCLICK, bcd_pkg::CFG_W'(phase_dc[p]));
			gappy = ($urandom_range(0, 3) != 0);
			// long receiver hold while items keep coming
			if (phase_db[p] == 50) begin
				gappy = 1'b0;
				hold_go = 1'b1;
			end
			sent = 0;
			run_lvl = level_q;
			while (sent < phase_n[p]) begin
				pick = $urandom_range(0, 9);
				if (pick == 9)
					run_lvl = $urandom_range(0, 1);
				else
					run_lvl = ~run_lvl;
				if (pick < 3) begin
					// bounce shorter than the debounce time when that is above 1
					len = $urandom_range(1, (phase_db[p] > 1) ? phase_db[p] - 1 : 1);
				end else if (pick < 8) begin
					// clean hold, sometimes long enough to miss the window
					len = phase_db[p] + $urandom_range(0,
						((phase_dc[p] < 200) ? phase_dc[p] : 200) / 2 + 2);
				end else begin
					len = $urandom_range(1, 4);
				end
				if (len > 150)
					len = 150;
				for (k = 0; k < len && sent < phase_n[p]; k++) begin
					t.button_level = run_lvl;
					// single-tick glitch
					if ($urandom_range(0, 19) == 0)
						t.button_level = ~run_lvl;
					t.detect_disabled = ($urandom_range(0, 15) == 0);
					t.status_clear = ($urandom_range(0, 24) == 0);
					send_tick(t, 1'b0, '0);
					sent++;
				end
			end
		end

		drain_wait();
		repeat (8) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("button_click_detector_core_test: done, clean");
		else
			$display("button_click_detector_core_test: done, errors");
		$finish;
	end

endmodule
